// File: rtl/core/gbts_pkg.sv
// gap buffer text store: shared types and constants
// no dependencies; used by the top level and the checker
`timescale 1ns / 1ps

package gbts_pkg;

  typedef enum logic [3:0] {
    ACT_INSERT       = 4'd0,
    ACT_MOVE         = 4'd1,
    ACT_LINE_UP      = 4'd2,
    ACT_LINE_DOWN    = 4'd3,
    ACT_DEL_LEFT     = 4'd4,
    ACT_DEL_RIGHT    = 4'd5,
    ACT_SEARCH_LEFT  = 4'd6,
    ACT_SEARCH_RIGHT = 4'd7,
    ACT_READ_AT      = 4'd8
  } gbts_action_t;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_RANGE = 2'd2
  } gbts_status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_MOVE,
    S_READ
  } gbts_state_t;

  localparam logic [7:0] NEWLINE_BYTE = 8'h0A;

endpackage

// File: rtl/core/gbts_ram.sv
// gap buffer text store: byte memory, one write and one registered read port
// no dependencies
`timescale 1ns / 1ps

module gbts_ram #(
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [7:0]               wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [7:0]               rdata
);

  logic [7:0] mem [DEPTH];
  logic [7:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/core/gap_buffer_text_store_top.sv
// gap buffer text store: top level with command sequencer and gap pointers
// depends on gbts_pkg and gbts_ram
`timescale 1ns / 1ps

// A command is taken when start is high and busy is low; its single result
// appears on the out_ ports for one cycle with out_valid and cannot be held
// off. Insert, delete, unused codes and a read_at beyond the text give their
// result in the cycle after the command, and an in-range read_at once its
// memory read has returned, from the read state. A cursor move shifts one
// byte per cycle through the memory's read and write ports. A search reads
// one byte per cycle from the cursor outward; line up and line down are such
// a search followed by a move. No clearing pass is needed after reset.

module gap_buffer_text_store_top #(
  parameter int CAPACITY = 4096
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [3:0]  in_action,
  input  logic [7:0]  in_byte_value,
  input  logic [12:0] in_amount,
  output logic        out_valid,
  output logic [1:0]  out_status,
  output logic [12:0] out_cursor,
  output logic [12:0] out_text_length,
  output logic [12:0] out_found_position,
  output logic [7:0]  out_data_byte
);

  localparam int PW = $clog2(CAPACITY + 1);
  localparam int AW = $clog2(CAPACITY);
  localparam int CW = (PW > 13) ? PW : 13;
  localparam logic [PW-1:0] CAP_P  = PW'(CAPACITY);
  localparam logic [AW-1:0] LAST_A = AW'(CAPACITY - 1);

  gbts_pkg::gbts_state_t  state_r, state_nxt;
  gbts_pkg::gbts_action_t act_r, act_nxt, in_act;
  gbts_pkg::gbts_status_t fin_status;

  logic [PW-1:0] gs_r, gs_nxt, ge_r, ge_nxt;
  logic [7:0]    byte_r, byte_nxt;
  logic [AW-1:0] pos_r, pos_nxt, rd_addr_r, rd_addr_nxt, mv_addr_r, mv_addr_nxt;
  logic          iss_r, iss_nxt, rd_v_r, rd_v_nxt, mv_v_r, mv_v_nxt;
  logic          mv_left_r, mv_left_nxt;
  logic [PW-1:0] cnt_r, cnt_nxt;

  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [7:0]    ram_wdata, ram_rdata;

  logic [PW-1:0] len, len_nxt, gs_m1, ge_m1, room, found_l, found_r, mv_tgt;
  logic [CW-1:0] amt_w, len_w, gs_w, rd_at_w, cur_w, lenn_w, found_w;
  logic [PW-1:0] fin_found;
  logic [7:0]    fin_data, tchar;
  logic          fin, mv_go, scan_left, scan_line, hit, scan_done;

  logic          out_valid_r;
  logic [1:0]    out_status_r;
  logic [12:0]   out_cursor_r, out_text_length_r, out_found_position_r;
  logic [7:0]    out_data_byte_r;

  gbts_ram #(.DEPTH(CAPACITY)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign in_act    = gbts_pkg::gbts_action_t'(in_action);
  assign busy      = (state_r != gbts_pkg::S_IDLE);
  assign len       = gs_r + (CAP_P - ge_r);
  assign len_nxt   = gs_nxt + (CAP_P - ge_nxt);
  assign gs_m1     = gs_r - PW'(1);
  assign ge_m1     = ge_r - PW'(1);
  assign room      = CAP_P - ge_r;
  assign amt_w     = CW'(in_amount);
  assign len_w     = CW'(len);
  assign gs_w      = CW'(gs_r);
  assign rd_at_w   = (amt_w < gs_w) ? amt_w : amt_w + CW'(ge_r - gs_r);

  assign scan_left = (act_r == gbts_pkg::ACT_SEARCH_LEFT) || (act_r == gbts_pkg::ACT_LINE_UP);
  assign scan_line = (act_r == gbts_pkg::ACT_LINE_UP) || (act_r == gbts_pkg::ACT_LINE_DOWN);
  assign tchar     = scan_line ? gbts_pkg::NEWLINE_BYTE : byte_r;
  assign hit       = rd_v_r && (ram_rdata == tchar);
  assign scan_done = hit || (!iss_r && !rd_v_r);
  assign found_l   = hit ? PW'(rd_addr_r) : '0;
  assign found_r   = hit ? (PW'(rd_addr_r) - ge_r) + gs_r : len;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      gbts_pkg::S_IDLE: begin
        if (start) begin
          unique case (in_act) inside
            gbts_pkg::ACT_MOVE: state_nxt = gbts_pkg::S_MOVE;
            gbts_pkg::ACT_LINE_UP, gbts_pkg::ACT_LINE_DOWN,
            gbts_pkg::ACT_SEARCH_LEFT, gbts_pkg::ACT_SEARCH_RIGHT:
              state_nxt = gbts_pkg::S_SCAN;
            gbts_pkg::ACT_READ_AT:
              state_nxt = (amt_w >= len_w) ? gbts_pkg::S_IDLE : gbts_pkg::S_READ;
            default: state_nxt = gbts_pkg::S_IDLE;
          endcase
        end
      end
      gbts_pkg::S_SCAN: begin
        if (scan_done) begin
          state_nxt = scan_line ? gbts_pkg::S_MOVE : gbts_pkg::S_IDLE;
        end
      end
      gbts_pkg::S_MOVE: begin
        if (cnt_r == '0) begin
          state_nxt = gbts_pkg::S_IDLE;
        end
      end
      gbts_pkg::S_READ: state_nxt = gbts_pkg::S_IDLE;
      default:          state_nxt = gbts_pkg::S_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    gs_nxt      = gs_r;
    ge_nxt      = ge_r;
    act_nxt     = act_r;
    byte_nxt    = byte_r;
    pos_nxt     = pos_r;
    iss_nxt     = iss_r;
    rd_v_nxt    = 1'b0;
    rd_addr_nxt = rd_addr_r;
    mv_v_nxt    = 1'b0;
    mv_addr_nxt = mv_addr_r;
    mv_left_nxt = mv_left_r;
    cnt_nxt     = cnt_r;
    ram_we      = 1'b0;
    ram_waddr   = '0;
    ram_wdata   = '0;
    ram_re      = 1'b0;
    ram_raddr   = '0;
    fin         = 1'b0;
    fin_status  = gbts_pkg::STAT_OK;
    fin_found   = '0;
    fin_data    = '0;
    mv_go       = 1'b0;
    mv_tgt      = '0;

    unique case (state_r)
      gbts_pkg::S_IDLE: begin
        if (start) begin
          act_nxt  = in_act;
          byte_nxt = in_byte_value;
          unique case (in_act) inside
            gbts_pkg::ACT_INSERT: begin
              fin = 1'b1;
              if (gs_r >= ge_r) begin
                fin_status = gbts_pkg::STAT_FULL;
              end else begin
                ram_we    = 1'b1;
                ram_waddr = gs_r[AW-1:0];
                ram_wdata = in_byte_value;
                gs_nxt    = gs_r + PW'(1);
              end
            end
            gbts_pkg::ACT_MOVE: begin
              mv_go  = 1'b1;
              mv_tgt = (amt_w > len_w) ? len : PW'(amt_w);
            end
            gbts_pkg::ACT_LINE_UP, gbts_pkg::ACT_SEARCH_LEFT: begin
              iss_nxt = (gs_r != '0);
              pos_nxt = gs_m1[AW-1:0];
            end
            gbts_pkg::ACT_LINE_DOWN, gbts_pkg::ACT_SEARCH_RIGHT: begin
              iss_nxt = (ge_r != CAP_P);
              pos_nxt = ge_r[AW-1:0];
            end
            gbts_pkg::ACT_DEL_LEFT: begin
              fin    = 1'b1;
              gs_nxt = (amt_w > gs_w) ? '0 : gs_r - PW'(amt_w);
            end
            gbts_pkg::ACT_DEL_RIGHT: begin
              fin    = 1'b1;
              ge_nxt = (amt_w > CW'(room)) ? CAP_P : ge_r + PW'(amt_w);
            end
            gbts_pkg::ACT_READ_AT: begin
              if (amt_w >= len_w) begin
                fin        = 1'b1;
                fin_status = gbts_pkg::STAT_RANGE;
              end else begin
                ram_re    = 1'b1;
                ram_raddr = rd_at_w[AW-1:0];
              end
            end
            default: fin = 1'b1;
          endcase
        end
      end

      gbts_pkg::S_SCAN: begin
        if (iss_r) begin
          ram_re      = 1'b1;
          ram_raddr   = pos_r;
          rd_v_nxt    = 1'b1;
          rd_addr_nxt = pos_r;
          if (scan_left) begin
            if (pos_r == '0) begin
              iss_nxt = 1'b0;
            end else begin
              pos_nxt = pos_r - AW'(1);
            end
          end else begin
            if (pos_r == LAST_A) begin
              iss_nxt = 1'b0;
            end else begin
              pos_nxt = pos_r + AW'(1);
            end
          end
        end
        if (scan_done) begin
          iss_nxt  = 1'b0;
          rd_v_nxt = 1'b0;
          if (scan_line) begin
            mv_go  = 1'b1;
            mv_tgt = scan_left ? found_l : (hit ? found_r + PW'(1) : len);
          end else begin
            fin       = 1'b1;
            fin_found = scan_left ? found_l : found_r;
          end
        end
      end

      gbts_pkg::S_MOVE: begin
        // write back the byte read in the previous cycle
        if (mv_v_r) begin
          ram_we    = 1'b1;
          ram_waddr = mv_addr_r;
          ram_wdata = ram_rdata;
        end
        if (cnt_r != '0) begin
          ram_re   = 1'b1;
          mv_v_nxt = 1'b1;
          cnt_nxt  = cnt_r - PW'(1);
          if (mv_left_r) begin
            ram_raddr   = gs_m1[AW-1:0];
            mv_addr_nxt = ge_m1[AW-1:0];
            gs_nxt      = gs_m1;
            ge_nxt      = ge_m1;
          end else begin
            ram_raddr   = ge_r[AW-1:0];
            mv_addr_nxt = gs_r[AW-1:0];
            gs_nxt      = gs_r + PW'(1);
            ge_nxt      = ge_r + PW'(1);
          end
        end else begin
          fin = 1'b1;
        end
      end

      gbts_pkg::S_READ: begin
        fin      = 1'b1;
        fin_data = ram_rdata;
      end

      default: begin
        fin = 1'b0;
      end
    endcase

    if (mv_go) begin
      mv_left_nxt = (mv_tgt < gs_r);
      cnt_nxt     = (mv_tgt < gs_r) ? gs_r - mv_tgt : mv_tgt - gs_r;
    end
  end

  assign cur_w   = CW'(gs_nxt);
  assign lenn_w  = CW'(len_nxt);
  assign found_w = CW'(fin_found);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= gbts_pkg::S_IDLE;
      gs_r        <= '0;
      ge_r        <= CAP_P;
      iss_r       <= 1'b0;
      rd_v_r      <= 1'b0;
      mv_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      gs_r        <= gs_nxt;
      ge_r        <= ge_nxt;
      iss_r       <= iss_nxt;
      rd_v_r      <= rd_v_nxt;
      mv_v_r      <= mv_v_nxt;
      out_valid_r <= fin;
    end
  end

  always_ff @(posedge clk) begin
    act_r     <= act_nxt;
    byte_r    <= byte_nxt;
    pos_r     <= pos_nxt;
    rd_addr_r <= rd_addr_nxt;
    mv_addr_r <= mv_addr_nxt;
    mv_left_r <= mv_left_nxt;
    cnt_r     <= cnt_nxt;
    if (fin) begin
      out_status_r         <= fin_status;
      out_cursor_r         <= cur_w[12:0];
      out_text_length_r    <= lenn_w[12:0];
      out_found_position_r <= found_w[12:0];
      out_data_byte_r      <= fin_data;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_cursor         = out_cursor_r;
  assign out_text_length    = out_text_length_r;
  assign out_found_position = out_found_position_r;
  assign out_data_byte      = out_data_byte_r;

endmodule

// File: rtl/core/gbts_checker.sv
// gap buffer text store: port-level checker and its bind to the top level
// depends on gbts_pkg and gap_buffer_text_store_top
`timescale 1ns / 1ps

module gbts_checker #(
  parameter int CAPACITY = 4096
) (
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic        out_valid,
  input logic [1:0]  out_status,
  input logic [12:0] out_cursor,
  input logic [12:0] out_text_length,
  input logic [12:0] out_found_position,
  input logic [7:0]  out_data_byte
);

  // every transaction either keeps the block busy or reports at once
  a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (busy || out_valid))
    else $error("transaction neither started work nor reported");

  // leaving busy always coincides with a result
  a_busy_end_result: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> out_valid)
    else $error("busy dropped without a result");

  // a rejected insert only happens with a full store
  a_full_length: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status == gbts_pkg::STAT_FULL)) |->
      (out_text_length == 13'(CAPACITY)))
    else $error("full status with store not full");

  // cursor never passes the end of the text
  a_cursor_in_text: assert property (@(posedge clk) disable iff (!rst_n)
    ((CAPACITY < 8192) && out_valid) |-> (out_cursor <= out_text_length))
    else $error("cursor beyond text length");

  // an out-of-range read reports no data
  a_range_no_data: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status == gbts_pkg::STAT_RANGE)) |->
      ((out_data_byte == 8'd0) && (out_found_position == 13'd0)))
    else $error("out-of-range read returned data");

endmodule

bind gap_buffer_text_store_top gbts_checker #(.CAPACITY(CAPACITY)) u_gbts_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .start              (start),
  .busy               (busy),
  .out_valid          (out_valid),
  .out_status         (out_status),
  .out_cursor         (out_cursor),
  .out_text_length    (out_text_length),
  .out_found_position (out_found_position),
  .out_data_byte      (out_data_byte)
);

// File: verif/tb_gap_buffer_text_store_top.sv
// self-checking testbench for the gap buffer text store: directed table, a text build-up
// and random editing sessions checked against a behavioural shadow of the text
// depends on gbts_pkg and gap_buffer_text_store_top
`timescale 1ns / 1ps

module tb_gap_buffer_text_store_top;

  localparam int TEXT_CAP = 4096;
  localparam int WATCHDOG_LIMIT = 50000;
  localparam int DRAIN_CYCLES = 40;
  localparam int DIRECTED_ROWS = 25;
  localparam int FILL_COUNT = 200;
  localparam int RANDOM_PHASE = 230;
  localparam logic [3:0] ACT_SPARE_FIRST = 4'd9;
  localparam logic [3:0] ACT_SPARE_LAST = 4'd15;

  typedef struct packed {
    logic [1:0]  status;
    logic [12:0] cursor;
    logic [12:0] text_length;
    logic [12:0] found;
    logic [7:0]  data;
  } edit_result_t;

  typedef struct packed {
    logic [3:0]   action;
    logic [7:0]   byte_value;
    logic [12:0]  amount;
    logic         fixed_exp;
    edit_result_t want;
  } cmd_row_t;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [3:0]  in_action = '0;
  logic [7:0]  in_byte_value = '0;
  logic [12:0] in_amount = '0;
  logic        out_valid;
  logic [1:0]  out_status;
  logic [12:0] out_cursor;
  logic [12:0] out_text_length;
  logic [12:0] out_found_position;
  logic [7:0]  out_data_byte;

  logic [7:0]   shadow_text [0:TEXT_CAP-1];
  int           shadow_gap_start;
  int           shadow_gap_end;
  edit_result_t pending_results [$];
  int           mismatches = 0;
  int           results_seen = 0;
  int           sent_count = 0;
  int           peak_length = 0;
  int           full_rejects = 0;
  int           calm_left = 0;
  int           idle_cycles = 0;

  cmd_row_t directed_rows [0:DIRECTED_ROWS-1] = '{
    '{gbts_pkg::ACT_READ_AT,      8'h00, 13'd0,    1'b1,
      '{gbts_pkg::STAT_RANGE, 13'd0, 13'd0, 13'd0, 8'h00}},
    '{gbts_pkg::ACT_SEARCH_LEFT,  8'h61, 13'd0,    1'b1,
      '{gbts_pkg::STAT_OK, 13'd0, 13'd0, 13'd0, 8'h00}},
    '{gbts_pkg::ACT_SEARCH_RIGHT, 8'h61, 13'd0,    1'b1,
      '{gbts_pkg::STAT_OK, 13'd0, 13'd0, 13'd0, 8'h00}},
    '{gbts_pkg::ACT_DEL_LEFT,     8'h00, 13'h1FFF, 1'b1,
      '{gbts_pkg::STAT_OK, 13'd0, 13'd0, 13'd0, 8'h00}},
    '{gbts_pkg::ACT_DEL_RIGHT,    8'hFF, 13'h1FFF, 1'b1,
      '{gbts_pkg::STAT_OK, 13'd0, 13'd0, 13'd0, 8'h00}},
    '{gbts_pkg::ACT_MOVE,         8'h00, 13'h1FFF, 1'b1,
      '{gbts_pkg::STAT_OK, 13'd0, 13'd0, 13'd0, 8'h00}},
    '{gbts_pkg::ACT_LINE_UP,      8'h00, 13'd0,    1'b1,
      '{gbts_pkg::STAT_OK, 13'd0, 13'd0, 13'd0, 8'h00}},
    '{gbts_pkg::ACT_LINE_DOWN,    8'h00, 13'd0,    1'b1,
      '{gbts_pkg::STAT_OK, 13'd0, 13'd0, 13'd0, 8'h00}},
    '{ACT_SPARE_LAST,             8'hFF, 13'h1FFF, 1'b1,
      '{gbts_pkg::STAT_OK, 13'd0, 13'd0, 13'd0, 8'h00}},
    '{gbts_pkg::ACT_INSERT,       8'h00, 13'h1FFF, 1'b1,
      '{gbts_pkg::STAT_OK, 13'd1, 13'd1, 13'd0, 8'h00}},
    '{gbts_pkg::ACT_INSERT,       8'hFF, 13'd0,    1'b1,
      '{gbts_pkg::STAT_OK, 13'd2, 13'd2, 13'd0, 8'h00}},
    '{gbts_pkg::ACT_INSERT,       8'h0A, 13'd0,    1'b1,
      '{gbts_pkg::STAT_OK, 13'd3, 13'd3, 13'd0, 8'h00}},
    '{gbts_pkg::ACT_INSERT,       8'h62, 13'd5,    1'b0, '0},
    '{gbts_pkg::ACT_READ_AT,      8'h00, 13'd0,    1'b1,
      '{gbts_pkg::STAT_OK, 13'd4, 13'd4, 13'd0, 8'h00}},
    '{gbts_pkg::ACT_READ_AT,      8'h00, 13'd1,    1'b1,
      '{gbts_pkg::STAT_OK, 13'd4, 13'd4, 13'd0, 8'hFF}},
    '{gbts_pkg::ACT_READ_AT,      8'h00, 13'd4,    1'b1,
      '{gbts_pkg::STAT_RANGE, 13'd4, 13'd4, 13'd0, 8'h00}},
    '{gbts_pkg::ACT_MOVE,         8'h00, 13'd1,    1'b0, '0},
    '{gbts_pkg::ACT_SEARCH_RIGHT, 8'h0A, 13'd0,    1'b0, '0},
    '{gbts_pkg::ACT_SEARCH_LEFT,  8'hFF, 13'd0,    1'b0, '0},
    '{gbts_pkg::ACT_LINE_DOWN,    8'h00, 13'd0,    1'b0, '0},
    '{gbts_pkg::ACT_LINE_UP,      8'h00, 13'd0,    1'b0, '0},
    '{gbts_pkg::ACT_DEL_RIGHT,    8'h00, 13'd1,    1'b0, '0},
    '{gbts_pkg::ACT_DEL_LEFT,     8'h00, 13'd1,    1'b0, '0},
    '{ACT_SPARE_FIRST,            8'h00, 13'd0,    1'b0, '0},
    '{gbts_pkg::ACT_MOVE,         8'h00, 13'd0,    1'b0, '0}
  };

  gap_buffer_text_store_top #(
    .CAPACITY(TEXT_CAP)
  ) uut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_action(in_action),
    .in_byte_value(in_byte_value),
    .in_amount(in_amount),
    .out_valid(out_valid),
    .out_status(out_status),
    .out_cursor(out_cursor),
    .out_text_length(out_text_length),
    .out_found_position(out_found_position),
    .out_data_byte(out_data_byte)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic int shadow_len();
    return shadow_gap_start + (TEXT_CAP - shadow_gap_end);
  endfunction

  function automatic void shift_gap(input int target);
    int n;
    if (target > shadow_len()) target = shadow_len();
    if (target < shadow_gap_start) begin
      n = shadow_gap_start - target;
      for (int i = n - 1; i >= 0; i--) begin
        shadow_text[shadow_gap_end - n + i] = shadow_text[target + i];
      end
      shadow_gap_start -= n;
      shadow_gap_end -= n;
    end else begin
      n = target - shadow_gap_start;
      for (int i = 0; i < n; i++) begin
        shadow_text[shadow_gap_start + i] = shadow_text[shadow_gap_end + i];
      end
      shadow_gap_start += n;
      shadow_gap_end += n;
    end
  endfunction

  function automatic int find_back(input logic [7:0] c);
    int p;
    p = shadow_gap_start;
    while (p > 0) begin
      p--;
      if (shadow_text[p] == c) return p;
    end
    return 0;
  endfunction

  function automatic int find_ahead(input logic [7:0] c);
    for (int p = shadow_gap_end; p < TEXT_CAP; p++) begin
      if (shadow_text[p] == c) return p - shadow_gap_end + shadow_gap_start;
    end
    return shadow_len();
  endfunction

  function automatic edit_result_t apply_edit(input logic [3:0] act, input logic [7:0] bv,
                                              input logic [12:0] amt);
    edit_result_t r;
    int room;
    r = '0;
    case (act)
      gbts_pkg::ACT_INSERT: begin
        if (shadow_gap_start >= shadow_gap_end) begin
          r.status = gbts_pkg::STAT_FULL;
          full_rejects++;
        end else begin
          shadow_text[shadow_gap_start] = bv;
          shadow_gap_start++;
        end
      end
      gbts_pkg::ACT_MOVE:      shift_gap(int'(amt));
      gbts_pkg::ACT_LINE_UP:   shift_gap(find_back(gbts_pkg::NEWLINE_BYTE));
      gbts_pkg::ACT_LINE_DOWN: shift_gap(find_ahead(gbts_pkg::NEWLINE_BYTE) + 1);
      gbts_pkg::ACT_DEL_LEFT:
        shadow_gap_start -= (int'(amt) > shadow_gap_start) ? shadow_gap_start : int'(amt);
      gbts_pkg::ACT_DEL_RIGHT: begin
        room = TEXT_CAP - shadow_gap_end;
        shadow_gap_end += (int'(amt) > room) ? room : int'(amt);
      end
      gbts_pkg::ACT_SEARCH_LEFT:  r.found = 13'(find_back(bv));
      gbts_pkg::ACT_SEARCH_RIGHT: r.found = 13'(find_ahead(bv));
      gbts_pkg::ACT_READ_AT: begin
        if (int'(amt) >= shadow_len()) r.status = gbts_pkg::STAT_RANGE;
        else if (int'(amt) < shadow_gap_start) r.data = shadow_text[amt];
        else r.data = shadow_text[int'(amt) + shadow_gap_end - shadow_gap_start];
      end
      default: ;
    endcase
    r.cursor = 13'(shadow_gap_start);
    r.text_length = 13'(shadow_len());
    if (shadow_len() > peak_length) peak_length = shadow_len();
    return r;
  endfunction

  function automatic logic [7:0] pick_byte();
    int k;
    k = $urandom_range(99);
    if (k < 15) return gbts_pkg::NEWLINE_BYTE;
    if (k < 70) return 8'(8'h61 + $urandom_range(3));
    return 8'($urandom_range(255));
  endfunction

  task automatic issue_edit(input logic [3:0] act, input logic [7:0] bv, input logic [12:0] amt,
                            input int idle_pct, input bit use_fixed = 1'b0,
                            input edit_result_t fixed = '0);
    int gap;
    edit_result_t predicted;
    gap = 0;
    if (calm_left > 0) calm_left--;
    else if ($urandom_range(99) < 3) calm_left = $urandom_range(30, 10);
    else if ($urandom_range(99) < idle_pct) gap = $urandom_range(6, 1);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_action <= act;
    in_byte_value <= bv;
    in_amount <= amt;
    do @(posedge clk); while (busy);
    predicted = apply_edit(act, bv, amt);
    pending_results.push_back(use_fixed ? fixed : predicted);
    sent_count++;
  endtask

  task automatic run_random(input int count, input int idle_pct);
    int r;
    int k;
    int len;
    logic [3:0] act;
    logic [7:0] bv;
    logic [12:0] amt;
    repeat (count) begin
      len = shadow_len();
      r = $urandom_range(99);
      bv = pick_byte();
      amt = 13'($urandom);
      if (len > 320 && r < 40) begin
        act = r[0] ? gbts_pkg::ACT_DEL_LEFT : gbts_pkg::ACT_DEL_RIGHT;
        amt = 13'($urandom_range(64));
      end else if (r < 35) begin
        act = gbts_pkg::ACT_INSERT;
      end else if (r < 47) begin
        act = gbts_pkg::ACT_MOVE;
        if ($urandom_range(9) < 8) amt = 13'($urandom_range(len));
      end else if (r < 52) begin
        act = gbts_pkg::ACT_LINE_UP;
      end else if (r < 57) begin
        act = gbts_pkg::ACT_LINE_DOWN;
      end else if (r < 69) begin
        act = (r < 63) ? gbts_pkg::ACT_DEL_LEFT : gbts_pkg::ACT_DEL_RIGHT;
        k = $urandom_range(9);
        if (k < 7) amt = 13'($urandom_range(8));
        else if (k < 9) amt = 13'($urandom_range(len));
      end else if (r < 77) begin
        act = gbts_pkg::ACT_SEARCH_LEFT;
      end else if (r < 85) begin
        act = gbts_pkg::ACT_SEARCH_RIGHT;
      end else if (r < 97) begin
        act = gbts_pkg::ACT_READ_AT;
        if ($urandom_range(9) < 8) amt = 13'($urandom_range(len));
      end else begin
        act = 4'($urandom_range(ACT_SPARE_LAST, ACT_SPARE_FIRST));
      end
      issue_edit(act, bv, amt, idle_pct);
    end
  endtask

  task automatic check_field(input string name, input logic [12:0] want_v,
                             input logic [12:0] got_v);
    if (got_v !== want_v) begin
      $error("%s: expected %0d, got %0d", name, want_v, got_v);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : result_check
    edit_result_t want;
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        $error("result transaction with nothing pending");
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        check_field("status", 13'(want.status), 13'(out_status));
        check_field("cursor", want.cursor, out_cursor);
        check_field("text_length", want.text_length, out_text_length);
        check_field("found_position", want.found, out_found_position);
        check_field("data_byte", 13'(want.data), 13'(out_data_byte));
        results_seen++;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    for (int i = 0; i < TEXT_CAP; i++) shadow_text[i] = 8'h00;
    shadow_gap_start = 0;
    shadow_gap_end = TEXT_CAP;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < DIRECTED_ROWS; i++) begin
      issue_edit(directed_rows[i].action, directed_rows[i].byte_value, directed_rows[i].amount,
                 0, directed_rows[i].fixed_exp, directed_rows[i].want);
    end

    // build up some two hundred bytes of text, then walk it
    issue_edit(gbts_pkg::ACT_MOVE, 8'h00, 13'h1FFF, 0);
    repeat (FILL_COUNT) begin
      issue_edit(gbts_pkg::ACT_INSERT, pick_byte(), 13'($urandom), 0);
    end
    issue_edit(gbts_pkg::ACT_MOVE, 8'h00, 13'd0, 0);
    issue_edit(gbts_pkg::ACT_LINE_DOWN, 8'h00, 13'd0, 0);
    issue_edit(gbts_pkg::ACT_SEARCH_RIGHT, pick_byte(), 13'd0, 0);
    issue_edit(gbts_pkg::ACT_READ_AT, 8'h00, 13'(TEXT_CAP - 1), 0);
    issue_edit(gbts_pkg::ACT_READ_AT, 8'h00, 13'(TEXT_CAP), 0);
    issue_edit(gbts_pkg::ACT_MOVE, 8'h00, 13'(TEXT_CAP / 2), 0);
    issue_edit(gbts_pkg::ACT_INSERT, 8'hAA, 13'd0, 0);
    issue_edit(gbts_pkg::ACT_LINE_UP, 8'h00, 13'd0, 0);
    issue_edit(gbts_pkg::ACT_SEARCH_LEFT, gbts_pkg::NEWLINE_BYTE, 13'd0, 0);
    issue_edit(gbts_pkg::ACT_MOVE, 8'h00, 13'h1FFF, 0);
    issue_edit(gbts_pkg::ACT_SEARCH_RIGHT, 8'h61, 13'd0, 0);
    issue_edit(gbts_pkg::ACT_MOVE, 8'h00, 13'd100, 0);
    issue_edit(gbts_pkg::ACT_DEL_RIGHT, 8'h00, 13'h1FFF, 0);
    issue_edit(gbts_pkg::ACT_DEL_LEFT, 8'h00, 13'h1FFF, 0);
    issue_edit(gbts_pkg::ACT_READ_AT, 8'h00, 13'd0, 0);

    run_random(RANDOM_PHASE, 0);
    run_random(RANDOM_PHASE, 67);
    run_random(RANDOM_PHASE, 0);
    run_random(RANDOM_PHASE, 29);

    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("summary: %0d edit transactions (%0d from the directed table), %0d results checked",
             sent_count, DIRECTED_ROWS, results_seen);
    $display("summary: text grew to %0d of %0d bytes, %0d inserts refused on a full buffer",
             peak_length, TEXT_CAP, full_rejects);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// File: gap_buffer_text_store_top.f
rtl/core/gbts_pkg.sv
rtl/core/gbts_ram.sv
rtl/core/gap_buffer_text_store_top.sv
rtl/core/gbts_checker.sv
verif/tb_gap_buffer_text_store_top.sv
